// File: src/timer_prescaler_compare_select_assert.svh
// assertion macros for the timer prescaler compare select block
// used by the top level; expects clk and rst_n in the including scope
`ifndef TIMER_PRESCALER_COMPARE_SELECT_ASSERT_SVH
`define TIMER_PRESCALER_COMPARE_SELECT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TPCS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TPCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tpcs_pkg.sv
// shared types and constants for the timer prescaler compare select block
// no dependencies
`timescale 1ns / 1ps

package tpcs_pkg;

    // field widths
    localparam int unsigned FREQ_W    = 32;
    localparam int unsigned DIV_W     = FREQ_W + 1;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned CMP_W     = 16;

    // prescaler table as shift amounts: 1, 8, 64, 256, 1024
    localparam int unsigned PRESC_COUNT = 5;
    localparam int unsigned PRESC_SHIFT [PRESC_COUNT] = '{0, 3, 6, 8, 10};

    // largest tick count whose compare value still fits in 16 bits
    localparam int unsigned TICK_LIMIT = 65536;

    typedef enum logic
    {
        STATUS_OK  = 1'b0,
        STATUS_ERR = 1'b1
    } status_t;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CMP_W-1:0] cmp_t;

endpackage

// File: src/tpcs_if.sv
// valid/ready channel interfaces for the request and result sides
// depends on tpcs_pkg
`timescale 1ns / 1ps

interface tpcs_in_if
    import tpcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] target_freq;

    modport source (output valid, output target_freq, input ready);
    modport sink   (input valid, input target_freq, output ready);
endinterface

interface tpcs_out_if
    import tpcs_pkg::*;
();
    logic    valid;
    logic    ready;
    status_t status;
    idx_t    prescaler_index;
    idx_t    clock_select;
    cmp_t    compare_value;

    modport source (output valid, output status, output prescaler_index,
                    output clock_select, output compare_value, input ready);
    modport sink   (input valid, input status, input prescaler_index,
                    input clock_select, input compare_value, output ready);
endinterface

// File: src/tpcs_div_stage.sv
// one restoring division step: constant clock dividend over twice the frequency
// depends on tpcs_pkg
`timescale 1ns / 1ps

module tpcs_div_stage
    import tpcs_pkg::*;
#(
    parameter int unsigned CW           = 24,
    parameter int unsigned CLOCK_HZ     = 16000000,
    parameter int unsigned DIVIDEND_BIT = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  logic             zero,
    input  logic [DIV_W-1:0] divisor,
    input  logic [CW-1:0]    rem,
    input  logic [CW-1:0]    quo,
    output logic             stage_valid,
    output logic             stage_zero,
    output logic [DIV_W-1:0] stage_divisor,
    output logic [CW-1:0]    stage_rem,
    output logic [CW-1:0]    stage_quo
);

    localparam int unsigned  TW       = DIV_W + 1;
    localparam logic [CW-1:0] DIVIDEND = CW'(CLOCK_HZ);

    logic             valid_reg;
    logic             zero_reg;
    logic [DIV_W-1:0] divisor_reg;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [CW-1:0]    quo_reg, quo_next;

    logic [CW:0]      shifted;
    logic [TW-1:0]    trial;
    logic [TW-1:0]    diff;
    logic             fits;

    // bring down the next dividend bit and try a subtract
    always_comb
    begin
        shifted  = {rem, DIVIDEND[DIVIDEND_BIT]};
        trial    = TW'(shifted);
        diff     = trial - {1'b0, divisor};
        fits     = trial >= {1'b0, divisor};
        rem_next = fits ? diff[CW-1:0] : shifted[CW-1:0];
        quo_next = {quo[CW-2:0], fits};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg    <= zero;
            divisor_reg <= divisor;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
        end
    end

    assign stage_valid   = valid_reg;
    assign stage_zero    = zero_reg;
    assign stage_divisor = divisor_reg;
    assign stage_rem     = rem_reg;
    assign stage_quo     = quo_reg;

endmodule

// File: src/tpcs_select.sv
// picks the first prescaler whose tick count fits and holds the result register
// depends on tpcs_pkg and tpcs_out_if
`timescale 1ns / 1ps

module tpcs_select
    import tpcs_pkg::*;
#(
    parameter int unsigned CW = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid,
    input  logic          zero,
    input  logic [CW-1:0] quo,
    tpcs_out_if.source    result
);

    logic    valid_reg;
    status_t status_reg, status_next;
    idx_t    index_reg, index_next;
    idx_t    csel_reg, csel_next;
    cmp_t    cmp_reg, cmp_next;

    logic [CW-1:0] ticks;
    logic [CW-1:0] ticks_m1;
    logic          found;

    // ticks for prescaler 2^k is the half-period quotient shifted right by k
    always_comb
    begin
        found       = 1'b0;
        status_next = STATUS_ERR;
        index_next  = '0;
        csel_next   = '0;
        cmp_next    = '0;
        ticks       = '0;
        ticks_m1    = '0;
        for (int i = 0; i < PRESC_COUNT; i++)
        begin
            ticks    = quo >> PRESC_SHIFT[i];
            ticks_m1 = ticks - CW'(1);
            if (!found && !zero && ticks != '0 && ticks <= CW'(TICK_LIMIT))
            begin
                found       = 1'b1;
                status_next = STATUS_OK;
                index_next  = IDX_W'(i);
                csel_next   = IDX_W'(i + 1);
                cmp_next    = ticks_m1[CMP_W-1:0];
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            csel_reg   <= csel_next;
            cmp_reg    <= cmp_next;
        end
    end

    assign result.valid           = valid_reg;
    assign result.status          = status_reg;
    assign result.prescaler_index = index_reg;
    assign result.clock_select    = csel_reg;
    assign result.compare_value   = cmp_reg;

endmodule

// File: src/timer_prescaler_compare_select.sv
// top level of the timer prescaler compare select block
// depends on tpcs_pkg, tpcs_if, tpcs_div_stage, tpcs_select and the assertion header
`timescale 1ns / 1ps

// Takes a toggle frequency in hertz and returns the clear-on-compare timer
// setting: the first of the prescalers 1, 8, 64, 256, 1024 whose tick count
// floor(CLOCK_HZ / (prescaler * 2 * freq)) lies in 1..65536, its clock-select
// code and the compare value (ticks - 1). Zero frequency, or no fitting
// prescaler, gives an error status with all other fields zero. One frequency
// is accepted every cycle while the result side is not stalled. CW is the bit
// width of CLOCK_HZ (24 at 16 MHz). The restoring divider forms the CW-bit
// quotient CLOCK_HZ / (2 * freq) one bit per register stage, followed by
// the selection stage that holds the result. A stall on the result side
// freezes the whole pipeline, nothing is dropped.

`include "timer_prescaler_compare_select_assert.svh"

module timer_prescaler_compare_select
    import tpcs_pkg::*;
#(
    parameter int unsigned CLOCK_HZ = 16000000
)
(
    input  logic        clk,
    input  logic        rst_n,
    tpcs_in_if.sink     request,
    tpcs_out_if.source  result
);

    localparam int unsigned CW = $clog2(CLOCK_HZ + 1);

    logic                  en;
    logic [CW:0]           vld;
    logic [CW:0]           zero;
    logic [DIV_W-1:0]      dvs [CW+1];
    logic [CW-1:0]         rem [CW+1];
    logic [CW-1:0]         quo [CW+1];

    // global advance: move whenever the result register is free or being taken
    assign en            = !result.valid || result.ready;
    assign request.ready = en;

    // divider entry: divisor is twice the frequency
    assign vld[0]  = request.valid;
    assign zero[0] = request.target_freq == '0;
    assign dvs[0]  = {request.target_freq, 1'b0};
    assign rem[0]  = '0;
    assign quo[0]  = '0;

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < CW; s++)
    begin : g_div
        tpcs_div_stage #(
            .CW           (CW),
            .CLOCK_HZ     (CLOCK_HZ),
            .DIVIDEND_BIT (CW - 1 - s)
        ) u_stage (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .valid         (vld[s]),
            .zero          (zero[s]),
            .divisor       (dvs[s]),
            .rem           (rem[s]),
            .quo           (quo[s]),
            .stage_valid   (vld[s+1]),
            .stage_zero    (zero[s+1]),
            .stage_divisor (dvs[s+1]),
            .stage_rem     (rem[s+1]),
            .stage_quo     (quo[s+1])
        );
    end

    // prescaler choice and result register
    tpcs_select #(
        .CW (CW)
    ) u_select (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .valid  (vld[CW]),
        .zero   (zero[CW]),
        .quo    (quo[CW]),
        .result (result)
    );

    // result consistency
    `TPCS_ASSERT_IMPL(a_csel_follows_index, result.valid && result.status == STATUS_OK, result.clock_select == result.prescaler_index + 3'd1, "clock select is not index plus one")
    `TPCS_ASSERT_IMPL(a_error_fields_zero, result.valid && result.status == STATUS_ERR, result.prescaler_index == '0 && result.clock_select == '0 && result.compare_value == '0, "error result carries nonzero fields")
    `TPCS_ASSERT_IMPL(a_index_in_table, result.valid && result.status == STATUS_OK, result.prescaler_index <= 3'd4, "prescaler index outside table")
    `TPCS_ASSERT_NEXT(a_stall_freezes_entry, result.valid && !result.ready, vld[0] == $past(vld[0]) || !request.ready || vld[1] == $past(vld[1]), "pipeline moved during a result stall")

endmodule
